>>> rtl/perpendicular_axis_finder_assert.svh
// Assertion macros for the perpendicular axis finder.
`ifndef PERPENDICULAR_AXIS_FINDER_ASSERT_SVH
`define PERPENDICULAR_AXIS_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
`define PAF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PAF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PAF_ASSERT_IMP(lbl, ante, cons, msg)
`define PAF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/paf_pkg.sv
package paf_pkg;

   localparam int AXIS_COUNT  = 73;
   localparam int MAX_MATCHES = 16;
   localparam int MAX_ORDER   = 6;
   localparam int TABLE_SIZE  = 73;
   localparam int SCAN_COUNT  = (AXIS_COUNT < TABLE_SIZE) ? AXIS_COUNT : TABLE_SIZE;
   localparam int IDX_W       = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;
   localparam int CNT_W       = $clog2(MAX_MATCHES + 1);
   localparam int ORD_W       = 3;
   // sum entries stay below 2^19 for order up to 6
   localparam int SW          = 20;

   typedef logic [SW-1:0] sval_type;
   typedef sval_type [2:0][2:0] smat_type;

   typedef struct packed {
      logic [2:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
      logic [2:0] rotation_order;
   } req_type;

   typedef struct packed {
      logic [2:0] axis_x, axis_y, axis_z;
      logic       found, last, overflow;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [1:0] {F_IDLE, F_SUM, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_SCAN, B_FLUSH} back_state_type;

   // candidate axis table, x in [8:6], y in [5:3], z in [2:0]
   function automatic logic [8:0] axis_of(input logic [6:0] idx);
      logic [8:0] v;
      case (idx)
         7'd0:  v = {3'sd1, 3'sd0, 3'sd0};
         7'd1:  v = {3'sd0, 3'sd1, 3'sd0};
         7'd2:  v = {3'sd0, 3'sd0, 3'sd1};
         7'd3:  v = {3'sd0, 3'sd1, 3'sd1};
         7'd4:  v = {3'sd1, 3'sd0, 3'sd1};
         7'd5:  v = {3'sd1, 3'sd1, 3'sd0};
         7'd6:  v = {3'sd0, 3'sd1, -3'sd1};
         7'd7:  v = {-3'sd1, 3'sd0, 3'sd1};
         7'd8:  v = {3'sd1, -3'sd1, 3'sd0};
         7'd9:  v = {3'sd1, 3'sd1, 3'sd1};
         7'd10: v = {-3'sd1, 3'sd1, 3'sd1};
         7'd11: v = {3'sd1, -3'sd1, 3'sd1};
         7'd12: v = {3'sd1, 3'sd1, -3'sd1};
         7'd13: v = {3'sd0, 3'sd1, 3'sd2};
         7'd14: v = {3'sd2, 3'sd0, 3'sd1};
         7'd15: v = {3'sd1, 3'sd2, 3'sd0};
         7'd16: v = {3'sd0, 3'sd2, 3'sd1};
         7'd17: v = {3'sd1, 3'sd0, 3'sd2};
         7'd18: v = {3'sd2, 3'sd1, 3'sd0};
         7'd19: v = {3'sd0, -3'sd1, 3'sd2};
         7'd20: v = {3'sd2, 3'sd0, -3'sd1};
         7'd21: v = {-3'sd1, 3'sd2, 3'sd0};
         7'd22: v = {3'sd0, -3'sd2, 3'sd1};
         7'd23: v = {3'sd1, 3'sd0, -3'sd2};
         7'd24: v = {-3'sd2, 3'sd1, 3'sd0};
         7'd25: v = {3'sd2, 3'sd1, 3'sd1};
         7'd26: v = {3'sd1, 3'sd2, 3'sd1};
         7'd27: v = {3'sd1, 3'sd1, 3'sd2};
         7'd28: v = {3'sd2, -3'sd1, -3'sd1};
         7'd29: v = {-3'sd1, 3'sd2, -3'sd1};
         7'd30: v = {-3'sd1, -3'sd1, 3'sd2};
         7'd31: v = {3'sd2, 3'sd1, -3'sd1};
         7'd32: v = {-3'sd1, 3'sd2, 3'sd1};
         7'd33: v = {3'sd1, -3'sd1, 3'sd2};
         7'd34: v = {3'sd2, -3'sd1, 3'sd1};
         7'd35: v = {3'sd1, 3'sd2, -3'sd1};
         7'd36: v = {-3'sd1, 3'sd1, 3'sd2};
         7'd37: v = {3'sd3, 3'sd1, 3'sd2};
         7'd38: v = {3'sd2, 3'sd3, 3'sd1};
         7'd39: v = {3'sd1, 3'sd2, 3'sd3};
         7'd40: v = {3'sd3, 3'sd2, 3'sd1};
         7'd41: v = {3'sd1, 3'sd3, 3'sd2};
         7'd42: v = {3'sd2, 3'sd1, 3'sd3};
         7'd43: v = {3'sd3, -3'sd1, 3'sd2};
         7'd44: v = {3'sd2, 3'sd3, -3'sd1};
         7'd45: v = {-3'sd1, 3'sd2, 3'sd3};
         7'd46: v = {3'sd3, -3'sd2, 3'sd1};
         7'd47: v = {3'sd1, 3'sd3, -3'sd2};
         7'd48: v = {-3'sd2, 3'sd1, 3'sd3};
         7'd49: v = {3'sd3, -3'sd1, -3'sd2};
         7'd50: v = {-3'sd2, 3'sd3, -3'sd1};
         7'd51: v = {-3'sd1, -3'sd2, 3'sd3};
         7'd52: v = {3'sd3, -3'sd2, -3'sd1};
         7'd53: v = {-3'sd1, 3'sd3, -3'sd2};
         7'd54: v = {-3'sd2, -3'sd1, 3'sd3};
         7'd55: v = {3'sd3, 3'sd1, -3'sd2};
         7'd56: v = {-3'sd2, 3'sd3, 3'sd1};
         7'd57: v = {3'sd1, -3'sd2, 3'sd3};
         7'd58: v = {3'sd3, 3'sd2, -3'sd1};
         7'd59: v = {-3'sd1, 3'sd3, 3'sd2};
         7'd60: v = {3'sd2, -3'sd1, 3'sd3};
         7'd61: v = {3'sd1, 3'sd1, 3'sd3};
         7'd62: v = {-3'sd1, 3'sd1, 3'sd3};
         7'd63: v = {3'sd1, -3'sd1, 3'sd3};
         7'd64: v = {-3'sd1, -3'sd1, 3'sd3};
         7'd65: v = {3'sd1, 3'sd3, 3'sd1};
         7'd66: v = {-3'sd1, 3'sd3, 3'sd1};
         7'd67: v = {3'sd1, 3'sd3, -3'sd1};
         7'd68: v = {-3'sd1, 3'sd3, -3'sd1};
         7'd69: v = {3'sd3, 3'sd1, 3'sd1};
         7'd70: v = {3'sd3, 3'sd1, -3'sd1};
         7'd71: v = {3'sd3, -3'sd1, 3'sd1};
         7'd72: v = {3'sd3, -3'sd1, -3'sd1};
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/paf_if.sv
interface paf_req_if;
   logic              valid;
   logic              ready;
   paf_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface paf_rsp_if;
   logic              valid;
   logic              ready;
   paf_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/paf_front.sv
module paf_front (
   input  logic                    clock,
   input  logic                    reset,
   paf_req_if.sink                 req,
   input  paf_pkg::queue_stat_type q_stat,
   output logic                    q_push,
   output paf_pkg::smat_type       q_data
);

   paf_pkg::front_state_type state_ff, state_in;
   logic signed [3:0]        p_ff [3][3];
   paf_pkg::smat_type        pw_ff, s_ff, prod;
   logic [2:0]               rem_ff;
   logic                     accept;

   logic signed [2:0] e [3][3];
   logic signed [9:0] det;
   logic [2:0]        ord;

   assign e[0][0] = req.data.e11;
   assign e[0][1] = req.data.e12;
   assign e[0][2] = req.data.e13;
   assign e[1][0] = req.data.e21;
   assign e[1][1] = req.data.e22;
   assign e[1][2] = req.data.e23;
   assign e[2][0] = req.data.e31;
   assign e[2][1] = req.data.e32;
   assign e[2][2] = req.data.e33;

   // determinant by cofactors on the incoming matrix
   always_comb begin
      det = 10'(e[0][0]) * (10'(e[1][1]) * 10'(e[2][2]) - 10'(e[1][2]) * 10'(e[2][1]))
          - 10'(e[0][1]) * (10'(e[1][0]) * 10'(e[2][2]) - 10'(e[1][2]) * 10'(e[2][0]))
          + 10'(e[0][2]) * (10'(e[1][0]) * 10'(e[2][1]) - 10'(e[1][1]) * 10'(e[2][0]));
   end

   // clamp the order into one to the maximum
   always_comb begin
      ord = req.data.rotation_order;
      if (ord == 3'd0) begin
         ord = 3'd1;
      end else if (32'(ord) > paf_pkg::MAX_ORDER) begin
         ord = 3'(paf_pkg::MAX_ORDER);
      end
   end

   // next power: pw times p
   always_comb begin
      logic signed [23:0] acc;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
               acc = acc + 24'($signed(pw_ff[i][k])) * 24'(p_ff[k][j]);
            end
            prod[i][j] = acc[paf_pkg::SW-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         paf_pkg::F_IDLE: if (req.valid) state_in = paf_pkg::F_SUM;
         paf_pkg::F_SUM:  if (rem_ff == 3'd0) state_in = paf_pkg::F_PUSH;
         paf_pkg::F_PUSH: if (!q_stat.full) state_in = paf_pkg::F_IDLE;
         default:         state_in = paf_pkg::F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready = 1'b0;
      q_push    = 1'b0;
      unique case (state_ff)
         paf_pkg::F_IDLE: req.ready = 1'b1;
         paf_pkg::F_PUSH: q_push = !q_stat.full;
         default: ;
      endcase
   end

   assign accept = req.valid && req.ready;
   assign q_data = s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= paf_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // load the proper rotation, then accumulate powers
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[i][j]  <= (det == 10'sd1) ? 4'(e[i][j]) : -4'(e[i][j]);
               pw_ff[i][j] <= (i == j) ? paf_pkg::SW'(1) : '0;
               s_ff[i][j]  <= (i == j) ? paf_pkg::SW'(1) : '0;
            end
         end
         rem_ff <= ord - 3'd1;
      end else if (state_ff == paf_pkg::F_SUM && rem_ff != 3'd0) begin
         pw_ff <= prod;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s_ff[i][j] <= s_ff[i][j] + prod[i][j];
            end
         end
         rem_ff <= rem_ff - 3'd1;
      end
   end

endmodule

>>> rtl/paf_queue.sv
module paf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  paf_pkg::smat_type       push_data,
   input  logic                    pop,
   output paf_pkg::smat_type       pop_data,
   output paf_pkg::queue_stat_type stat
);

   paf_pkg::smat_type mem_ff [2];
   logic              wr_ff, rd_ff;
   logic [1:0]        cnt_ff;

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign pop_data   = mem_ff[rd_ff];

   // store on push
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> rtl/paf_back.sv
module paf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  paf_pkg::queue_stat_type q_stat,
   input  paf_pkg::smat_type       q_data,
   output logic                    q_pop,
   paf_rsp_if.source               rsp
);

   paf_pkg::back_state_type   state_ff, state_in;
   paf_pkg::smat_type         s_ff;
   logic [paf_pkg::IDX_W-1:0] idx_ff;
   logic [paf_pkg::CNT_W-1:0] cnt_ff;
   logic                      pend_ff;
   logic [8:0]                pend_axis_ff;
   logic                      rsp_valid_ff;
   paf_pkg::rsp_type          rsp_data_ff;

   logic [8:0] axis;
   logic       match, out_free, at_end, at_limit, stall;
   logic       emit_mid, emit_ovf, emit_end, take;

   assign axis     = paf_pkg::axis_of(7'(idx_ff));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign at_end   = (32'(idx_ff) == paf_pkg::SCAN_COUNT - 1);
   assign at_limit = (32'(cnt_ff) == paf_pkg::MAX_MATCHES);

   // test S times the candidate axis for zero
   always_comb begin
      logic signed [23:0] dot;
      match = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dot = 24'($signed(s_ff[i][0])) * 24'($signed(axis[8:6]))
             + 24'($signed(s_ff[i][1])) * 24'($signed(axis[5:3]))
             + 24'($signed(s_ff[i][2])) * 24'($signed(axis[2:0]));
         if (dot != 24'sd0) match = 1'b0;
      end
   end

   assign stall = match && pend_ff && !out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         paf_pkg::B_IDLE:  if (!q_stat.empty) state_in = paf_pkg::B_SCAN;
         paf_pkg::B_SCAN: begin
            if (!stall) begin
               if (match && at_limit) state_in = paf_pkg::B_IDLE;
               else if (at_end)       state_in = paf_pkg::B_FLUSH;
            end
         end
         paf_pkg::B_FLUSH: if (out_free) state_in = paf_pkg::B_IDLE;
         default:          state_in = paf_pkg::B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      take     = 1'b0;
      emit_mid = 1'b0;
      emit_ovf = 1'b0;
      emit_end = 1'b0;
      unique case (state_ff)
         paf_pkg::B_IDLE: q_pop = !q_stat.empty;
         paf_pkg::B_SCAN: begin
            if (!stall && match) begin
               if (at_limit) begin
                  emit_ovf = 1'b1;
               end else begin
                  emit_mid = pend_ff;
                  take     = 1'b1;
               end
            end
         end
         paf_pkg::B_FLUSH: emit_end = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= paf_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s_ff    <= q_data;
         idx_ff  <= '0;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (state_ff == paf_pkg::B_SCAN && !stall) begin
         idx_ff <= idx_ff + 1'b1;
         if (take) begin
            pend_ff      <= 1'b1;
            pend_axis_ff <= axis;
            cnt_ff       <= cnt_ff + 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_mid || emit_ovf || emit_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_mid || emit_ovf || emit_end) begin
         rsp_data_ff.axis_x   <= pend_ff ? pend_axis_ff[8:6] : 3'd0;
         rsp_data_ff.axis_y   <= pend_ff ? pend_axis_ff[5:3] : 3'd0;
         rsp_data_ff.axis_z   <= pend_ff ? pend_axis_ff[2:0] : 3'd0;
         rsp_data_ff.found    <= pend_ff;
         rsp_data_ff.last     <= emit_ovf || emit_end;
         rsp_data_ff.overflow <= emit_ovf;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule

>>> rtl/perpendicular_axis_finder.sv
// Perpendicular axis finder. Each request carries a 3x3 integer matrix and a
// rotation order n; the block answers with every table axis v (73 entries, in
// table order) for which (I + P + ... + P^(n-1)) v = 0, P being the proper
// rotation, up to 16 responses, the final one flagged last (and overflow if
// matches were cut off); no match gives one response with found low. The front
// end forms the sum with one matrix product per cycle, then hands it to a
// two-entry queue, so it can take the next request while the back end scans;
// the back end scans one table axis per cycle unless a held response stalls
// it. That table scan sets the sustained request rate.
`include "perpendicular_axis_finder_assert.svh"

module perpendicular_axis_finder (
   input  logic       clock,
   input  logic       reset,
   paf_req_if.sink    req_bus,
   paf_rsp_if.source  rsp_bus
);

   paf_pkg::queue_stat_type q_stat;
   paf_pkg::smat_type       push_data, pop_data;
   logic                    push, pop;

   paf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_stat (q_stat),
      .q_push (push),
      .q_data (push_data)
   );

   paf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   paf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .q_data (pop_data),
      .q_pop  (pop),
      .rsp    (rsp_bus)
   );

   `PAF_ASSERT_IMP(a_nofind_last, rsp_bus.valid && !rsp_bus.data.found, rsp_bus.data.last && !rsp_bus.data.overflow, "no-match response must be last")
   `PAF_ASSERT_IMP(a_ovf_last, rsp_bus.valid && rsp_bus.data.overflow, rsp_bus.data.last && rsp_bus.data.found, "overflow only on final match")
   `PAF_ASSERT_NXT(a_busy_after_req, req_bus.valid && req_bus.ready, !req_bus.ready, "front end must be busy after a request")
   `PAF_ASSERT_IMP(a_queue_sane, push, !q_stat.full, "push into full queue")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   logic clock;
   logic reset;

   paf_req_if req_bus ();
   paf_rsp_if rsp_bus ();

   perpendicular_axis_finder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   typedef struct {
      logic [2:0]       m[9];
      logic [2:0]       order;
      int               n_exp;    // -1: use predictor, else typed count of results
      paf_pkg::rsp_type first;    // typed first result where n_exp >= 0
   } vector_type;

   paf_pkg::rsp_type axis_queue[$];
   int               fail_count;
   int               sent;
   int               send_idle_pct;
   int               recv_idle_pct;
   bit               recv_hold;
   bit               typed_check;
   paf_pkg::rsp_type typed_first;

   // candidate axes, same order as the block scans them
   const int axis_list[73][3] = '{
      '{1,0,0},'{0,1,0},'{0,0,1},'{0,1,1},'{1,0,1},'{1,1,0},
      '{0,1,-1},'{-1,0,1},'{1,-1,0},'{1,1,1},'{-1,1,1},'{1,-1,1},
      '{1,1,-1},'{0,1,2},'{2,0,1},'{1,2,0},'{0,2,1},'{1,0,2},
      '{2,1,0},'{0,-1,2},'{2,0,-1},'{-1,2,0},'{0,-2,1},'{1,0,-2},
      '{-2,1,0},'{2,1,1},'{1,2,1},'{1,1,2},'{2,-1,-1},'{-1,2,-1},
      '{-1,-1,2},'{2,1,-1},'{-1,2,1},'{1,-1,2},'{2,-1,1},'{1,2,-1},
      '{-1,1,2},'{3,1,2},'{2,3,1},'{1,2,3},'{3,2,1},'{1,3,2},
      '{2,1,3},'{3,-1,2},'{2,3,-1},'{-1,2,3},'{3,-2,1},'{1,3,-2},
      '{-2,1,3},'{3,-1,-2},'{-2,3,-1},'{-1,-2,3},'{3,-2,-1},'{-1,3,-2},
      '{-2,-1,3},'{3,1,-2},'{-2,3,1},'{1,-2,3},'{3,2,-1},'{-1,3,2},
      '{2,-1,3},'{1,1,3},'{-1,1,3},'{1,-1,3},'{-1,-1,3},'{1,3,1},
      '{-1,3,1},'{1,3,-1},'{-1,3,-1},'{3,1,1},'{3,1,-1},'{3,-1,1},
      '{3,-1,-1}};

   // compute the perpendicular axes of one request and queue them
   function automatic int predict_axes(input logic [2:0] m[9], input logic [2:0] ord);
      longint p[3][3], pw[3][3], t[3][3], s[3][3];
      longint det, acc;
      int     nord, cnt;
      bit     more, hit;
      paf_pkg::rsp_type r;
      more = 0;
      cnt  = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            p[i][j] = longint'($signed(m[i*3+j]));
      det = p[0][0]*(p[1][1]*p[2][2]-p[1][2]*p[2][1])
          - p[0][1]*(p[1][0]*p[2][2]-p[1][2]*p[2][0])
          + p[0][2]*(p[1][0]*p[2][1]-p[1][1]*p[2][0]);
      if (det != 1)
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) p[i][j] = -p[i][j];
      nord = (ord == 0) ? 1 :
             ((ord > paf_pkg::MAX_ORDER) ? paf_pkg::MAX_ORDER : int'(ord));
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            pw[i][j] = (i == j);
            s[i][j]  = pw[i][j];
         end
      for (int k = 1; k < nord; k++) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int q = 0; q < 3; q++) acc += pw[i][q] * p[q][j];
               t[i][j] = acc;
            end
         pw = t;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) s[i][j] += pw[i][j];
      end
      for (int a = 0; a < 73; a++) begin
         hit = 1;
         for (int i = 0; i < 3; i++)
            if (s[i][0]*axis_list[a][0] + s[i][1]*axis_list[a][1]
                + s[i][2]*axis_list[a][2] != 0) hit = 0;
         if (!hit) continue;
         if (cnt >= paf_pkg::MAX_MATCHES) begin
            more = 1;
            break;
         end
         r.axis_x = 3'(axis_list[a][0]);
         r.axis_y = 3'(axis_list[a][1]);
         r.axis_z = 3'(axis_list[a][2]);
         r.found = 1; r.last = 0; r.overflow = 0;
         axis_queue.insert(axis_queue.size(), r);
         cnt++;
      end
      if (cnt == 0) begin
         r = '0;
         r.last = 1;
         axis_queue.insert(axis_queue.size(), r);
         return 1;
      end
      r = axis_queue.pop_back();
      r.last = 1;
      r.overflow = more;
      axis_queue.insert(axis_queue.size(), r);
      return cnt;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("tb_top: errors");
      $finish;
   end

   task automatic report_mismatch(input paf_pkg::rsp_type want, input paf_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display({"mismatch: expected x=%0d y=%0d z=%0d f=%b l=%b o=%b,",
                   " got x=%0d y=%0d z=%0d f=%b l=%b o=%b"},
            $signed(want.axis_x), $signed(want.axis_y), $signed(want.axis_z),
            want.found, want.last, want.overflow,
            $signed(got.axis_x), $signed(got.axis_y), $signed(got.axis_z),
            got.found, got.last, got.overflow);
   endtask

   // check each accepted response against the oldest expectation
   always @(posedge clock) begin
      paf_pkg::rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (axis_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("response with nothing expected");
         end else begin
            want = axis_queue.pop_front();
            if (typed_check) begin
               if (want != typed_first) report_mismatch(typed_first, want);
               typed_check <= 0;
            end
            if (rsp_bus.data.axis_x !== want.axis_x || rsp_bus.data.axis_y !== want.axis_y
                || rsp_bus.data.axis_z !== want.axis_z || rsp_bus.data.found !== want.found
                || rsp_bus.data.last !== want.last
                || rsp_bus.data.overflow !== want.overflow)
               report_mismatch(want, rsp_bus.data);
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (recv_hold) rsp_bus.ready <= 0;
         else rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one request and hold it until accepted
   task automatic send_request(input logic [2:0] m[9], input logic [2:0] ord);
      paf_pkg::req_type d;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      d.e11 = m[0]; d.e12 = m[1]; d.e13 = m[2];
      d.e21 = m[3]; d.e22 = m[4]; d.e23 = m[5];
      d.e31 = m[6]; d.e32 = m[7]; d.e33 = m[8];
      d.rotation_order = ord;
      req_bus.data  <= d;
      req_bus.valid <= 1;
      do @(posedge clock); while (!req_bus.ready);
      void'(predict_axes(m, ord));
      sent++;
      @(negedge clock);
   endtask

   task automatic random_matrix(output logic [2:0] m[9], output logic [2:0] ord);
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) m[i] = 3'($urandom);
      if (kind < 6) begin
         // signed permutation matrix: a genuine rotation or rotoinversion
         int perm[3];
         perm = '{0, 1, 2};
         perm.shuffle();
         for (int i = 0; i < 9; i++) m[i] = 0;
         for (int i = 0; i < 3; i++) m[i*3+perm[i]] = $urandom_range(1) ? 3'd1 : 3'b111;
      end else if (kind < 8) begin
         for (int i = 0; i < 9; i++) m[i] = 3'($signed($urandom_range(2)) - 1);
      end
      ord = (kind < 8) ? 3'($urandom_range(6, 1)) : 3'($urandom);
   endtask

   vector_type directed[$];

   initial begin
      logic [2:0] m[9];
      logic [2:0] ord;
      vector_type v;
      fail_count = 0; sent = 0; recv_hold = 0; typed_check = 0;
      send_idle_pct = 37; recv_idle_pct = 76;
      req_bus.valid = 0;
      req_bus.data  = '0;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed rows; n_exp >= 0 rows carry a typed first response
      v.n_exp = -1; v.first = '0;
      // identity, order 1: S = I, nothing is perpendicular
      v.m = '{1,0,0, 0,1,0, 0,0,1}; v.order = 1; v.n_exp = 1;
      v.first = '{axis_x:0, axis_y:0, axis_z:0, found:0, last:1, overflow:0};
      directed.insert(directed.size(), v);
      // order zero behaves as order 1
      v.order = 0; directed.insert(directed.size(), v);
      // zero matrix order 1 (det 0 negates, S still I)
      v.m = '{0,0,0, 0,0,0, 0,0,0}; directed.insert(directed.size(), v);
      // identity at order 2: S = 2I, no match
      v.m = '{1,0,0, 0,1,0, 0,0,1}; v.order = 2; directed.insert(directed.size(), v);
      // minus identity, order 2: det -1 negates it back to I, so S = 2I, no match
      v.m = '{7,0,0, 0,7,0, 0,0,7}; v.order = 2; directed.insert(directed.size(), v);
      // twofold about x, order 2: S = diag(2,0,0), the y axis comes first of eight
      v.m = '{1,0,0, 0,7,0, 0,0,7}; v.order = 2; v.n_exp = 8;
      v.first = '{axis_x:0, axis_y:1, axis_z:0, found:1, last:0, overflow:0};
      directed.insert(directed.size(), v);
      v.n_exp = -1;
      // fourfold about z, order 4 and saturated orders
      v.m = '{0,7,0, 1,0,0, 0,0,1}; v.order = 4; directed.insert(directed.size(), v);
      v.order = 7; directed.insert(directed.size(), v);
      v.order = 6; directed.insert(directed.size(), v);
      // twofold about x
      v.m = '{1,0,0, 0,7,0, 0,0,7}; v.order = 2; directed.insert(directed.size(), v);
      // threefold along body diagonal, rotoinversion too
      v.m = '{0,0,1, 1,0,0, 0,1,0}; v.order = 3; directed.insert(directed.size(), v);
      v.m = '{0,0,7, 7,0,0, 0,7,0}; v.order = 3; directed.insert(directed.size(), v);
      // sixfold hexagonal
      v.m = '{1,7,0, 1,0,0, 0,0,1}; v.order = 6; directed.insert(directed.size(), v);
      v.order = 5; directed.insert(directed.size(), v);
      // field extremes: all -4, all 3, mixed, zero matrix at the maximum order
      v.m = '{4,4,4, 4,4,4, 4,4,4}; v.order = 7; directed.insert(directed.size(), v);
      v.m = '{3,3,3, 3,3,3, 3,3,3}; v.order = 6; directed.insert(directed.size(), v);
      v.m = '{3,4,3, 4,3,4, 3,4,3}; v.order = 3; directed.insert(directed.size(), v);
      v.m = '{0,0,0, 0,0,0, 0,0,0}; v.order = 6; directed.insert(directed.size(), v);

      foreach (directed[k]) begin
         if (directed[k].n_exp >= 0) begin
            // drop the request and let earlier responses drain so the typed row lines up
            req_bus.valid <= 0;
            wait (axis_queue.size() == 0);
            @(negedge clock);
            typed_first = directed[k].first;
            typed_check = 1;
         end
         send_request(directed[k].m, directed[k].order);
      end

      // random phases with differing stall profiles
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle_pct = 76; recv_idle_pct = 37; end
         if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         for (int k = 0; k < 100; k++) begin
            random_matrix(m, ord);
            if (phase == 0 && k == 40) recv_hold = 1;
            send_request(m, ord);
            if (phase == 0 && k == 60) begin
               // sender pauses until every response has arrived
               req_bus.valid <= 0;
               wait (axis_queue.size() == 0);
               @(negedge clock);
            end
         end
      end
      req_bus.valid <= 0;
      wait (axis_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (recv_hold);
      repeat (2000) @(posedge clock);
      recv_hold = 0;
   end

endmodule
